### hdl/mccs_pkg.sv
`default_nettype none
package mccs_pkg;

  localparam int OP_W       = 2;
  localparam int COIN_W     = 10;
  localparam int TGT_W      = 10;
  localparam int COUNT_W    = 10;
  localparam int ST_W       = 2;
  localparam int ENTRY_W    = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_UNREACHABLE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE       = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL        = 2'd3;

  // all-ones entry marks an amount that cannot be made
  localparam logic [ENTRY_W-1:0] NO_WAY = 11'h7FF;

  typedef struct packed {
    logic accept;       // take the request on the input port
    logic init;         // write entry zero, start at amount one
    logic issue;        // read the next coin into the scan pipeline
    logic write_entry;  // store the best count for the current amount
    logic emit;         // move the result into the output register
  } mccs_cmd_t;

  typedef struct packed {
    logic solve_work;   // accepted request is a solve that needs the table
    logic no_coins;
    logic last_coin;
    logic pipe_busy;
    logic last_amount;
    logic out_free;
  } mccs_sts_t;

endpackage
`default_nettype wire

### hdl/mccs_ram.sv
`default_nettype none
module mccs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hdl/mccs_ctrl.sv
`default_nettype none
module mccs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire mccs_pkg::mccs_sts_t sts_i,
  output mccs_pkg::mccs_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.solve_work ? S_INIT : S_DONE;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = sts_i.no_coins ? S_WRITE : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_coin) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_entry = 1'b1;
        if (sts_i.last_amount) begin
          state_d = S_DONE;
        end else if (!sts_i.no_coins) begin
          state_d = S_SCAN;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### hdl/mccs_dp.sv
`default_nettype none
module mccs_dp #(
  parameter int MAX_COINS  = 16,
  parameter int MAX_TARGET = 1023
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [mccs_pkg::OP_W-1:0]             s_tuser_i,
  input  wire logic [mccs_pkg::IN_DATA_W-1:0]        s_tdata_i,
  output logic                                       m_tvalid_o,
  input  wire logic                                  m_tready_i,
  output logic      [mccs_pkg::OUT_DATA_W-1:0]       m_tdata_o,
  output logic      [mccs_pkg::ST_W-1:0]             m_tuser_o,
  input  wire mccs_pkg::mccs_cmd_t                   cmd_i,
  output mccs_pkg::mccs_sts_t                        sts_o
);

  localparam int CoinAw   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CntW     = $clog2(MAX_COINS + 1);
  localparam int TblDepth = (MAX_TARGET < 1023) ? MAX_TARGET + 1 : 1024;
  localparam int TblAw    = $clog2(TblDepth);

  logic [mccs_pkg::OP_W-1:0]   op;
  logic [mccs_pkg::COIN_W-1:0] coin_in;
  logic [mccs_pkg::TGT_W-1:0]  tgt_in;
  logic                        in_range, coin_full, add_ok;

  logic [CntW-1:0]                total_q;
  logic [CoinAw-1:0]              k_q;
  logic [TblAw-1:0]               amt_q;
  logic [mccs_pkg::TGT_W-1:0]     tgt_q;
  logic [mccs_pkg::ENTRY_W-1:0]   best_q;
  logic                           v1_q, v2_q, use2_q;
  logic [mccs_pkg::COUNT_W-1:0]   res_count_q;
  logic [mccs_pkg::ST_W-1:0]      res_status_q;
  logic                           out_valid_q;
  logic [mccs_pkg::COUNT_W-1:0]   out_count_q;
  logic [mccs_pkg::ST_W-1:0]      out_status_q;

  logic [mccs_pkg::COIN_W-1:0]    coin_rd;
  logic [mccs_pkg::ENTRY_W-1:0]   tbl_rd;
  logic                           use1;
  logic [mccs_pkg::TGT_W-1:0]     amt_ext, below;
  logic                           tbl_we;
  logic [TblAw-1:0]               tbl_waddr;
  logic [mccs_pkg::ENTRY_W-1:0]   tbl_wdata;
  logic [mccs_pkg::ENTRY_W:0]     cand;
  logic                           better;

  assign op        = s_tuser_i;
  assign coin_in   = s_tdata_i[mccs_pkg::COIN_W-1:0];
  assign tgt_in    = s_tdata_i[mccs_pkg::COIN_W +: mccs_pkg::TGT_W];
  assign in_range  = 32'(tgt_in) <= 32'(MAX_TARGET);
  assign coin_full = (total_q == CntW'(MAX_COINS));
  assign add_ok    = cmd_i.accept && (op == mccs_pkg::OP_ADD) &&
                     (coin_in != '0) && !coin_full;

  mccs_ram #(
    .Width (mccs_pkg::COIN_W),
    .Depth (MAX_COINS)
  ) u_coin_ram (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (CoinAw'(total_q)),
    .wdata_i (coin_in),
    .raddr_i (k_q),
    .rdata_o (coin_rd)
  );

  // stage one: coin is known, fetch the entry one coin below
  assign amt_ext = mccs_pkg::TGT_W'(amt_q);
  assign use1    = (coin_rd != '0) && (coin_rd <= amt_ext);
  assign below   = amt_ext - coin_rd;

  assign tbl_we    = cmd_i.init || cmd_i.write_entry;
  assign tbl_waddr = cmd_i.init ? '0 : amt_q;
  assign tbl_wdata = cmd_i.init ? '0 : best_q;

  mccs_ram #(
    .Width (mccs_pkg::ENTRY_W),
    .Depth (TblDepth)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (below[TblAw-1:0]),
    .rdata_o (tbl_rd)
  );

  // stage two: keep the least count
  assign cand   = {1'b0, tbl_rd} + 12'd1;
  assign better = v2_q && use2_q && (tbl_rd != mccs_pkg::NO_WAY) &&
                  (cand < {1'b0, best_q});

  assign sts_o.solve_work  = (op == mccs_pkg::OP_SOLVE) && in_range && (tgt_in != '0);
  assign sts_o.no_coins    = (total_q == '0);
  assign sts_o.last_coin   = (CntW'(k_q) == total_q - CntW'(1));
  assign sts_o.pipe_busy   = v1_q || v2_q;
  assign sts_o.last_amount = (amt_ext == tgt_q);
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && op == mccs_pkg::OP_CLEAR) begin
        total_q <= '0;
      end else if (add_ok) begin
        total_q <= total_q + CntW'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    use2_q <= use1;
    if (cmd_i.accept) begin
      tgt_q       <= tgt_in;
      res_count_q <= '0;
      if (op == mccs_pkg::OP_ADD && coin_in != '0 && coin_full) begin
        res_status_q <= mccs_pkg::ST_FULL;
      end else if (op == mccs_pkg::OP_SOLVE && !in_range) begin
        res_status_q <= mccs_pkg::ST_RANGE;
      end else begin
        res_status_q <= mccs_pkg::ST_OK;
      end
    end
    if (cmd_i.init) begin
      amt_q  <= TblAw'(1);
      k_q    <= '0;
      best_q <= mccs_pkg::NO_WAY;
    end
    if (cmd_i.issue) begin
      k_q <= k_q + CoinAw'(1);
    end
    if (better) begin
      best_q <= cand[mccs_pkg::ENTRY_W-1:0];
    end
    if (cmd_i.write_entry) begin
      if (sts_o.last_amount) begin
        if (best_q == mccs_pkg::NO_WAY) begin
          res_status_q <= mccs_pkg::ST_UNREACHABLE;
        end else begin
          res_count_q <= best_q[mccs_pkg::COUNT_W-1:0];
        end
      end else begin
        amt_q  <= amt_q + TblAw'(1);
        k_q    <= '0;
        best_q <= mccs_pkg::NO_WAY;
      end
    end
    if (cmd_i.emit) begin
      out_count_q  <= res_count_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(mccs_pkg::OUT_DATA_W - mccs_pkg::COUNT_W){1'b0}}, out_count_q};
  assign m_tuser_o  = out_status_q;

endmodule
`default_nettype wire

### hdl/min_coin_count_solver.sv
`default_nettype none
// channel  dir  tdata                                  tuser
// s_*      in   [9:0] coin_value, [19:10] target_amount [1:0] operation
// m_*      out  [9:0] min_count                        [1:0] status
//
// One request at a time. Clear, add, unused codes, target zero or out of
// range: result passes through the done state into the output register.
// Solve: time set by the coin scan, one table read per coin through the single
// read port of the table RAM.
// rst_ni clears the coin count; no clearing pass is needed.
// A result waiting on m_tready_i holds; a new request is taken meanwhile.
module min_coin_count_solver #(
  parameter int MAX_COINS  = 16,
  parameter int MAX_TARGET = 1023
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [mccs_pkg::IN_DATA_W-1:0]    s_tdata_i,  // coin_value, target_amount
  input  wire logic [mccs_pkg::OP_W-1:0]         s_tuser_i,  // operation
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic      [mccs_pkg::OUT_DATA_W-1:0]   m_tdata_o,  // min_count
  output logic      [mccs_pkg::ST_W-1:0]         m_tuser_o   // status
);

  mccs_pkg::mccs_cmd_t cmd;
  mccs_pkg::mccs_sts_t sts;

  mccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mccs_dp #(
    .MAX_COINS  (MAX_COINS),
    .MAX_TARGET (MAX_TARGET)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // table entry never written while a coin read is still in flight
  a_write_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_entry |-> !sts.pipe_busy)
    else $error("table write with scan pipeline busy");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("second request taken while busy");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !$past(m_tvalid_o) |-> $past(cmd.emit))
    else $error("result appeared without emit");

endmodule
`default_nettype wire
